FILE: rtl/core/ksxh_pkg.sv
// ----------------------------------------------------------------------------
// ksxh_pkg
// Shared types, constants and key ROM for the keyed shift/xor hash.
// ----------------------------------------------------------------------------
`default_nettype none

package ksxh_pkg;

  localparam int unsigned HASH_W    = 32;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned KEY_BYTES = 32;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_BYTES);
  localparam int unsigned ROUNDS    = 2 * KEY_BYTES;
  localparam int unsigned ROUND_W   = $clog2(ROUNDS);

  localparam int unsigned SHIFT_A_LEFT  = 5;
  localparam int unsigned SHIFT_A_RIGHT = 2;
  localparam int unsigned SHIFT_B_RIGHT = 2;
  localparam int unsigned SHIFT_B_LEFT  = 3;

  localparam logic [KEY_W-1:0] KEY_ROM [KEY_BYTES] = '{
    "N", "T", "M", "4", "N", "2", "I", "2",
    "Y", "m", "F", "i", "O", "W", "I", "w",
    "N", "z", "g", "z", "Y", "m", "V", "i",
    "Y", "W", "F", "j", "Y", "j", "c", "2"
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ksxh_state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic               load;   // capture seed into hash register
    logic               step;   // apply one round
    logic [ROUND_W-1:0] round;  // current round, MSB selects second pass
  } ksxh_ctrl_t;

  function automatic logic [KEY_W-1:0] key_byte(input logic [KEY_IDX_W-1:0] idx);
    return KEY_ROM[idx];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ksxh_round.sv
// ----------------------------------------------------------------------------
// ksxh_round
// Shared round unit: one hash round per use, pass chosen by round MSB.
// ----------------------------------------------------------------------------
`default_nettype none

module ksxh_round (
  input  wire logic [ksxh_pkg::HASH_W-1:0]  hash_i,
  input  wire logic [ksxh_pkg::ROUND_W-1:0] round_i,
  output logic      [ksxh_pkg::HASH_W-1:0]  hash_o
);
  import ksxh_pkg::*;

  logic [HASH_W-1:0] key_ext;
  logic [HASH_W-1:0] mix;
  logic              second_pass;

  assign second_pass = round_i[ROUND_W-1];
  assign key_ext = {{(HASH_W-KEY_W){1'b0}}, key_byte(round_i[KEY_IDX_W-1:0])};

  always_comb begin
    if (second_pass) begin
      mix = ((hash_i - key_ext) >> SHIFT_B_RIGHT) + (hash_i << SHIFT_B_LEFT);
    end else begin
      mix = (hash_i << SHIFT_A_LEFT) + key_ext + (hash_i >> SHIFT_A_RIGHT);
    end
  end

  assign hash_o = hash_i ^ mix;

endmodule

`default_nettype wire

FILE: rtl/core/ksxh_ctrl.sv
// ----------------------------------------------------------------------------
// ksxh_ctrl
// Sequencer: accepts a word, steps the round counter, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ksxh_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output ksxh_pkg::ksxh_ctrl_t     ctrl_o
);
  import ksxh_pkg::*;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

  ksxh_state_t        state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    unique case (state_r)
      ST_IDLE: begin
        round_nxt = '0;
        if (in_tvalid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        round_nxt = round_r + 1'b1;
        if (round_r == LAST_ROUND) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    ctrl_o.load  = 1'b0;
    ctrl_o.step  = 1'b0;
    ctrl_o.round = round_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        ctrl_o.load = in_tvalid;
      end
      ST_RUN:  ctrl_o.step = 1'b1;
      ST_DONE: out_tvalid  = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/keyed_shift_xor_hash.sv
// ----------------------------------------------------------------------------
// keyed_shift_xor_hash
// 32-bit seed to 32-bit digest over 64 keyed shift/add/xor rounds.
// ----------------------------------------------------------------------------
// The seed loads at the accept edge, then one round per cycle for 64
//   rounds. The single round unit is reused for every round, with one
//   word in flight: no new seed is accepted until the digest is taken.
// Reset: synchronous, active low; returns the sequencer to idle. The hash
//   register holds payload only and is not reset.
`default_nettype none

module keyed_shift_xor_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] seed
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [31:0] digest
);
  import ksxh_pkg::*;

  ksxh_ctrl_t        ctrl;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] round_out;

  // Sequencer: idle -> 64 rounds -> hold result until taken.
  ksxh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl_o     (ctrl)
  );

  // Shared round unit; first 32 rounds JS style, next 32 the second mix.
  ksxh_round u_round (
    .hash_i  (hash_r),
    .round_i (ctrl.round),
    .hash_o  (round_out)
  );

  always_comb begin
    hash_nxt = hash_r;
    if (ctrl.load) begin
      hash_nxt = in_tdata;
    end else if (ctrl.step) begin
      hash_nxt = round_out;
    end
  end

  // Hash register doubles as the output register while the word waits.
  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
  end

  assign out_tdata = hash_r;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_shift_xor_hash.
// Seeds go in on the input stream and digests come back on the result stream.
// A scoreboard predicts each digest from the accepted seed with its own
// two-pass keyed round loop and checks results in order. Both stream sides
// idle at random, with one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------

module testbench;
  import ksxh_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1600;
  localparam int unsigned QUIET_FROM   = 300;   // stretch with no idling at all
  localparam int unsigned QUIET_TO     = 450;
  localparam int unsigned HOLD_AT      = 900;   // seeds sent when the hold-off starts
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 2 * ROUNDS + 8;
  // worst case per word: busy time + longest input gap + longest result stall, x4 margin
  localparam longint unsigned TIMEOUT_NS = 20_000_000;

  // Expected digests in arrival order, computed from accepted seeds.
  class digest_tracker;
    logic [HASH_W-1:0] expected_digests[$];

    // Two passes over the key ROM: JS-hash rounds, then the subtract/shift
    // rounds. All 32-bit wrap, logical shifts.
    function logic [HASH_W-1:0] js_two_pass_digest(logic [HASH_W-1:0] seed);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] k;
      logic [HASH_W-1:0] diff;
      h = seed;
      for (int i = 0; i < KEY_BYTES; i++) begin
        k = {{(HASH_W-KEY_W){1'b0}}, KEY_ROM[i]};
        h = h ^ ((h << SHIFT_A_LEFT) + k + (h >> SHIFT_A_RIGHT));
      end
      for (int i = 0; i < KEY_BYTES; i++) begin
        k    = {{(HASH_W-KEY_W){1'b0}}, KEY_ROM[i]};
        diff = h - k;  // may go below zero, wraps before the shift
        h    = h ^ ((diff >> SHIFT_B_RIGHT) + (h << SHIFT_B_LEFT));
      end
      return h;
    endfunction

    function void note_seed(logic [HASH_W-1:0] seed);
      expected_digests = {expected_digests, js_two_pass_digest(seed)};
    endfunction

    // Returns 1 on match; on failure fills in a one-line reason.
    function bit check_digest(logic [HASH_W-1:0] got, output string why);
      logic [HASH_W-1:0] want;
      why = "";
      if (expected_digests.size() == 0) begin
        why = $sformatf("digest %08h arrived with no seed pending", got);
        return 1'b0;
      end
      want = expected_digests.pop_front();
      if (got !== want) begin
        why = $sformatf("digest got %08h want %08h", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_digests.size();
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [HASH_W-1:0] in_tdata   = '0;    // [31:0] seed
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [HASH_W-1:0] out_tdata;          // [31:0] digest

  // idling controls, changed only with nonblocking writes at the clock edge
  logic quiet    = 1'b0;
  logic hold_off = 1'b0;

  int unsigned   ready_stall = 0;
  int unsigned   seeds_sent  = 0;
  int unsigned   mismatches  = 0;
  digest_tracker sb;

  always #6 clk = ~clk;

  keyed_shift_xor_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Idle length: mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Seeds biased toward the edges of the 32-bit range now and then.
  function automatic logic [HASH_W-1:0] pick_seed();
    int unsigned sel;
    int unsigned bitpos;
    sel    = $urandom_range(0, 9);
    bitpos = $urandom_range(0, HASH_W - 1);
    case (sel)
      0: return HASH_W'($urandom_range(0, 255));
      1: return ~HASH_W'($urandom_range(0, 255));
      2: return HASH_W'(1) << bitpos;
      3: return ~(HASH_W'(1) << bitpos);
      default: return HASH_W'($urandom());
    endcase
  endfunction

  // Offer one seed, hold it until the block takes it. Valid stays high
  // across back-to-back words; it only drops when a gap is taken.
  task automatic send_seed(input logic [HASH_W-1:0] seed);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= seed;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_seed(seed);
    seeds_sent++;
  endtask

  // Result side backpressure: random stalls, none during the quiet stretch,
  // forced low for the whole hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (ready_stall != 0) begin
      ready_stall <= ready_stall - 1;
      out_tready  <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      ready_stall <= pick_gap();
      out_tready  <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Every accepted digest is checked against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    string why;
    if (rst_n && out_tvalid && out_tready) begin
      if (!sb.check_digest(out_tdata, why)) report_mismatch(why);
    end
  end

  // Long hold-off on the result side while seeds keep being offered, so the
  // single word in flight blocks and in_tready stays low for a while.
  initial begin : result_hold_off
    wait (seeds_sent == HOLD_AT);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_NS * 1ns);
    $display("** keyed_shift_xor_hash: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [HASH_W-1:0] directed_seeds[$];
    sb = new();
    // extremes, alternating patterns, lone bits, small seeds where the
    // second-pass subtraction is likely to dip below zero early on
    directed_seeds = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
      32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
      32'h0000_004E, 32'h0000_0031, 32'h0000_0002, 32'h0000_0020,
      32'h4000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'hF0F0_F0F0,
      32'h0F0F_0F0F, 32'h0000_0100, 32'h1234_5678, 32'hFEDC_BA98
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_seeds[i]) send_seed(directed_seeds[i]);

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n == QUIET_FROM) quiet <= 1'b1;
      if (n == QUIET_TO)   quiet <= 1'b0;
      send_seed(pick_seed());
    end
    in_tvalid <= 1'b0;

    // wait for the last digests, then let the pipe sit for a full pass
    // in case anything stray comes out
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** keyed_shift_xor_hash: PASSED **");
    end else begin
      $display("** keyed_shift_xor_hash: FAILED **");
    end
    $finish;
  end

endmodule
